>>> hdl/itda_pkg.sv
package itda_pkg;

  // Default operand width and the characters the block emits
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam logic [7:0]  CHAR_ZERO       = 8'd48;
  localparam logic [7:0]  CHAR_MINUS      = 8'd45;

  // Magnitude bits folded into the BCD register per converter cycle
  localparam int unsigned BITS_PER_STEP   = 4;
  // Entries in the queue between front and back end
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Double-dabble correction: a BCD digit of five or more gets three added
  localparam logic [3:0]  DABBLE_LIMIT    = 4'd5;
  localparam logic [3:0]  DABBLE_ADD      = 4'd3;

  // Decimal digits needed for any value below 2**width (1233/4096 ~ log10 2)
  function automatic int unsigned num_digits(input int unsigned width);
    return ((width * 1233) >> 12) + 1;
  endfunction

endpackage

>>> hdl/itda_if.sv
interface itda_in_if #(
  parameter int unsigned VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itda_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

>>> hdl/itda_front.sv
module itda_front #(
  parameter int unsigned VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
  itda_in_if.sink           in_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output logic [VALUE_WIDTH:0] push_data_o
);
  import itda_pkg::*;

  logic [VALUE_WIDTH-1:0] raw;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;

  // Most negative value wraps to 2**(W-1), which fits unsigned in W bits
  assign raw = VALUE_WIDTH'(in_i.value);
  assign neg = raw[VALUE_WIDTH-1];
  assign mag = neg ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;
  assign push_data_o  = {neg, mag};

endmodule

>>> hdl/itda_queue.sv
module itda_queue #(
  parameter int unsigned WIDTH = itda_pkg::VALUE_WIDTH_DEF + 1,
  parameter int unsigned DEPTH = itda_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import itda_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> hdl/itda_conv.sv
module itda_conv #(
  parameter int unsigned VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned BCD_W       = 4 * itda_pkg::num_digits(VALUE_WIDTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  logic [VALUE_WIDTH:0] pop_data_i,
  output logic                 res_valid_o,
  input  logic                 res_take_i,
  output logic                 res_neg_o,
  output logic [BCD_W-1:0]     res_bcd_o
);
  import itda_pkg::*;

  localparam int unsigned NDIG  = BCD_W / 4;
  localparam int unsigned NSTEP = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned PAD_W = NSTEP * BITS_PER_STEP;
  localparam int unsigned CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  logic             busy_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PAD_W-1:0] mag_q, mag_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic             pop;

  assign pop_ready_o = !busy_q && (!done_q || res_take_i);
  assign pop         = pop_valid_i && pop_ready_o;
  assign res_valid_o = done_q;
  assign res_neg_o   = neg_q;
  assign res_bcd_o   = bcd_q;

  // Shift-add-3 over several magnitude bits per cycle
  always_comb begin
    bcd_d = bcd_q;
    mag_d = mag_q;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_d[d*4 +: 4] >= DABBLE_LIMIT) begin
          bcd_d[d*4 +: 4] = bcd_d[d*4 +: 4] + DABBLE_ADD;
        end
      end
      bcd_d = {bcd_d[BCD_W-2:0], mag_d[PAD_W-1]};
      mag_d = {mag_d[PAD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (res_take_i) begin
        done_q <= 1'b0;
      end
      if (pop) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NSTEP - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      neg_q <= pop_data_i[VALUE_WIDTH];
      mag_q <= PAD_W'(pop_data_i[VALUE_WIDTH-1:0]);
      bcd_q <= '0;
    end else if (busy_q) begin
      mag_q <= mag_d;
      bcd_q <= bcd_d;
    end
  end

endmodule

>>> hdl/itda_emit.sv
module itda_emit #(
  parameter int unsigned BCD_W = 4 * itda_pkg::num_digits(itda_pkg::VALUE_WIDTH_DEF)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  output logic             res_take_o,
  input  logic             res_neg_i,
  input  logic [BCD_W-1:0] res_bcd_i,
  itda_out_if.source       out_o
);
  import itda_pkg::*;

  localparam int unsigned NDIG  = BCD_W / 4;
  localparam int unsigned IDX_W = $clog2(NDIG);

  logic             busy_q, sign_q;
  logic [IDX_W-1:0] idx_q, top;
  logic [BCD_W-1:0] bcd_q;
  logic             out_valid_q, out_last_q;
  logic [7:0]       out_char_q;
  logic             out_free, emit_go, cur_last;
  logic [3:0]       digit;

  // Most significant non-zero digit; zero leaves the units digit
  always_comb begin
    top = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (res_bcd_i[i*4 +: 4] != 4'd0) begin
        top = IDX_W'(i);
      end
    end
  end

  assign digit      = bcd_q[idx_q*4 +: 4];
  assign out_free   = !out_valid_q || out_o.ready;
  assign emit_go    = busy_q && out_free;
  assign cur_last   = !sign_q && (idx_q == '0);
  assign res_take_o = res_valid_i && (!busy_q || (emit_go && cur_last));

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = out_char_q;
  assign out_o.is_last   = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      sign_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (res_take_o) begin
        busy_q <= 1'b1;
        sign_q <= res_neg_i;
        idx_q  <= top;
      end else if (emit_go) begin
        if (sign_q) begin
          sign_q <= 1'b0;
        end else begin
          idx_q <= idx_q - 1'b1;
        end
        if (cur_last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_char_q <= sign_q ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digit});
      out_last_q <= cur_last;
    end
    if (res_take_o) begin
      bcd_q <= res_bcd_i;
    end
  end

endmodule

>>> hdl/int_to_decimal_ascii.sv
// Path from input request to first character: queue, shift-add-3 converter
//   at 4 bits per step, hand-over to the emitter, output register.
// Request rate is limited by the shift-add-3 converter and the one-character output
//   port; the queue accepts new requests while earlier ones are still converting.
// Reset: asynchronous active low; clears queue pointers and all valid flags.
module int_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itda_in_if.sink     in_i,
  itda_out_if.source  out_o
);
  import itda_pkg::*;

  // BCD register width: four bits per decimal digit of the widest magnitude
  localparam int unsigned BCD_W = 4 * num_digits(VALUE_WIDTH);

  // Front end to queue: sign flag above the magnitude
  logic                 push_valid, push_ready;
  logic [VALUE_WIDTH:0] push_data;
  // Queue to converter
  logic                 pop_valid, pop_ready;
  logic [VALUE_WIDTH:0] pop_data;
  // Converter to character emitter
  logic                 res_valid, res_take, res_neg;
  logic [BCD_W-1:0]     res_bcd;

  // Classify sign and form the unsigned magnitude
  itda_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Short queue decouples accepting requests from conversion
  itda_queue #(
    .WIDTH (VALUE_WIDTH + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Binary to BCD; holds its result until the emitter takes it, so the
  // next conversion overlaps the current run of characters
  itda_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .BCD_W       (BCD_W)
  ) u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_neg_o   (res_neg),
    .res_bcd_o   (res_bcd)
  );

  // Walk digits from the leading non-zero one down, sign first
  itda_emit #(
    .BCD_W (BCD_W)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_take_o  (res_take),
    .res_neg_i   (res_neg),
    .res_bcd_i   (res_bcd),
    .out_o       (out_o)
  );

  // A finished conversion is held until the emitter takes it
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_take |=> res_valid && $stable(res_bcd) && $stable(res_neg))
    else $error("converter result lost before hand-over");

  // The minus sign never ends a run
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.char_code == CHAR_MINUS) |-> !out_o.is_last)
    else $error("minus sign marked as last character");

  // Only the minus sign or a decimal digit leaves the block
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.char_code == CHAR_MINUS) ||
                    ((out_o.char_code >= CHAR_ZERO) &&
                     (out_o.char_code <= CHAR_ZERO + 8'd9)))
    else $error("illegal character code");

endmodule

>>> dv/itda_text_checker.sv
`timescale 1ns / 100ps
module itda_text_checker #(
  parameter int unsigned VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [VALUE_WIDTH-1:0] in_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [7:0]                    out_char_i,
  input  logic                          out_last_i,
  output int unsigned                   err_count_o,
  output int unsigned                   pending_o
);
  import itda_pkg::*;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } text_char_t;

  text_char_t expected_text[$];
  text_char_t want_char;
  text_char_t seen_char;

  // Append the decimal text of one request to the expected characters
  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] raw);
    logic                 negative;
    logic [VALUE_WIDTH:0] magnitude;
    logic [3:0]           digits[$];
    text_char_t           ch;
    negative  = raw[VALUE_WIDTH-1];
    magnitude = {1'b0, raw};
    // widen before negating so the most negative value keeps its magnitude
    if (negative) magnitude = {1'b1, {VALUE_WIDTH{1'b0}}} - magnitude;
    do begin
      digits.push_front(4'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) begin
      ch.char_code = CHAR_MINUS;
      ch.is_last   = 1'b0;
      expected_text.push_back(ch);
    end
    foreach (digits[k]) begin
      ch.char_code = CHAR_ZERO + 8'(digits[k]);
      ch.is_last   = (k == digits.size() - 1);
      expected_text.push_back(ch);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_text.delete();
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_text(in_value_i);
      if (out_valid_i && out_ready_i) begin
        seen_char.char_code = out_char_i;
        seen_char.is_last   = out_last_i;
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected char_code %0d is_last %0b", $time,
                   out_char_i, out_last_i);
          err_count_o <= err_count_o + 1;
        end else begin
          want_char = expected_text.pop_front();
          if (seen_char !== want_char) begin
            $display("%0t: expected char_code %0d is_last %0b, got char_code %0d is_last %0b",
                     $time, want_char.char_code, want_char.is_last,
                     seen_char.char_code, seen_char.is_last);
            err_count_o <= err_count_o + 1;
          end
        end
      end
      pending_o <= expected_text.size();
    end
  end

endmodule

>>> dv/tb_int_to_decimal_ascii.sv
`timescale 1ns / 100ps
module tb_int_to_decimal_ascii;
  import itda_pkg::*;

  localparam int unsigned VALUE_WIDTH  = VALUE_WIDTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 330;
  localparam int unsigned DRAIN_AT     = 160;
  // Generous bound for the slowest legal run, in nanoseconds
  localparam longint      TIMEOUT_NS   = 3_000_000;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned open_chars;

  itda_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_if ();
  itda_out_if                             out_if ();

  int_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Prediction and comparison live in the checker; this module only drives
  itda_text_checker #(.VALUE_WIDTH(VALUE_WIDTH)) text_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .in_value_i  (in_if.value),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_char_i  (out_if.char_code),
    .out_last_i  (out_if.is_last),
    .err_count_o (fail_count),
    .pending_o   (open_chars)
  );

  // Corner values: zero, single digits, decade boundaries, both extremes,
  // the most negative value and alternating bit patterns
  int corner_values[20] = '{
    0, 1, -1, 5, -7, 9, 10, -10, 99, 100, -100,
    999999999, 1000000000, -1000000000,
    32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
    32'h5555_5555, 32'hAAAA_AAAA, 1234567890
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern: switch between always ready, coin toss,
  // heavy stalling and a fixed duty cycle, each held for a random stretch
  int unsigned stall_mode  = 0;
  int unsigned mode_left   = 0;
  int unsigned stall_phase = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0: begin
        out_if.ready <= 1'b1;
      end
      1: begin
        out_if.ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_if.ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_if.ready <= ((stall_phase % 5) < 2);
      end
    endcase
  end

  // Present one request at the falling edge and hold it until accepted;
  // return at the falling edge after the accepting rising edge
  task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every expected character has come out
  task automatic drain_output();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (open_chars != 0) @(negedge clk);
  endtask

  // Spread values over every digit count, both signs and the extremes
  function automatic logic signed [VALUE_WIDTH-1:0] random_value();
    int unsigned                   kind;
    int unsigned                   ndig;
    int unsigned                   low_bound;
    logic signed [VALUE_WIDTH-1:0] v;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      v = $urandom;
    end else if (kind < 8) begin
      ndig      = $urandom_range(1, 9);
      low_bound = (ndig == 1) ? 0 : 10 ** (ndig - 1);
      v         = $urandom_range(10 ** ndig - 1, low_bound);
      if ($urandom_range(0, 1)) v = -v;
    end else if (kind == 8) begin
      v = 32'h7FFF_FFFF - $urandom_range(0, 50);
    end else begin
      v = 32'h8000_0000 + $urandom_range(0, 50);
    end
    return v;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    bit          drained;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    sent         = 0;
    drained      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, back to back
    foreach (corner_values[i]) send_value(corner_values[i]);
    // Hold the sender until the block has emptied
    drain_output();

    // Random part in bursts with random gaps, some gaps zero
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_value(random_value());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        in_if.value <= $urandom;
        repeat (gap) @(negedge clk);
      end
      if (!drained && sent >= DRAIN_AT) begin
        drain_output();
        drained = 1'b1;
      end
    end

    // Let the last characters out, then allow for any stray ones
    in_if.valid <= 1'b0;
    while (open_chars != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    if (fail_count == 0 && open_chars == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
